// ----- rtl/core/wwmd_pkg.sv -----
// ----------------------------------------------------------------------------
// wwmd_pkg
// Shared types, constants and byte helpers for the whole-word match detector.
// ----------------------------------------------------------------------------
package wwmd_pkg;

    localparam int BYTE_W          = 8;
    localparam int PATTERN_MAX_DEF = 16;
    localparam int PAT_BYTES       = 16;
    localparam int LEN_W           = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_W           = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_t;

    // What one cell reports about the byte it is about to hold
    typedef struct packed {
        logic valid;
        logic letter;
        logic eq;
    } cell_stat_t;

    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/wwmd_cell.sv -----
// ----------------------------------------------------------------------------
// wwmd_cell
// One window position: holds a text byte and its valid bit, compares the
// byte it is about to take against its slot of the pattern.
// ----------------------------------------------------------------------------
module wwmd_cell #(
    parameter int INDEX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                clear,
    input  logic [wwmd_pkg::BYTE_W-1:0]         in_byte,
    input  logic                                in_valid,
    input  wwmd_pkg::pattern_t                  pattern,
    input  logic [wwmd_pkg::LEN_W-1:0]          len,
    output logic [wwmd_pkg::BYTE_W-1:0]         out_byte,
    output logic                                out_valid,
    output wwmd_pkg::cell_stat_t                stat
);
    import wwmd_pkg::*;

    localparam logic [LEN_W-1:0] IDX = LEN_W'(INDEX);

    logic [BYTE_W-1:0] byte_reg;
    logic              valid_reg;
    logic              active;
    logic [LEN_W-1:0]  slot;
    logic [BYTE_W-1:0] pat_byte;

    // Pattern byte len-1-INDEX lines up with this position
    always_comb
    begin
        active      = IDX < len;
        slot        = len - IDX - LEN_W'(1);
        pat_byte    = pattern[slot[$clog2(PAT_BYTES)-1:0]];
        stat.valid  = in_valid;
        stat.letter = is_letter(in_byte);
        stat.eq     = !active || (fold_case(pat_byte) == fold_case(in_byte));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid && !clear;
        end
    end

    assign out_byte  = byte_reg;
    assign out_valid = valid_reg;

endmodule

// ----- rtl/core/wwmd_out_skid.sv -----
// ----------------------------------------------------------------------------
// wwmd_out_skid
// Two-entry output buffer for the found flag: output register plus skid.
// ----------------------------------------------------------------------------
module wwmd_out_skid (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  logic  push_data,
    output logic  can_push,
    output logic  out_valid,
    output logic  out_data,
    input  logic  out_ready
);
    logic out_valid_reg;
    logic out_valid_next;
    logic out_data_reg;
    logic out_data_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic skid_data_reg;
    logic skid_data_next;
    logic pop;

    assign pop = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while output register is empty");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !can_push |-> (out_valid && skid_valid_reg))
        else $error("input stalled without a full buffer");

    a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("output word lost while stalled");

endmodule

// ----- rtl/core/whole_word_match_detector_top.sv -----
// ----------------------------------------------------------------------------
// whole_word_match_detector_top
// Case-insensitive whole-word search of a configured pattern in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Text enters one byte per word on the s_ group; s_tlast marks the final
//   byte of a string. For each string exactly one word leaves on the m_
//   group, after the last byte: m_tdata[0] is 1 if the pattern appeared with
//   a non-letter or the string edge on both sides. Other bytes give no word.
//   The pattern (up to PATTERN_MAX bytes) and its length are loaded through
//   cfg_we / cfg_index / cfg_data while no string is in flight.
//   Throughput: one byte per clock while s_tready is high. A row of
//   PATTERN_MAX+1 window cells shifts the text along and compares every
//   position in the same cycle; the result word for a string is registered
//   in the output register, or in the skid stage if an earlier one waits.
//   Stall: a result waiting on m_tready parks in the output register; one
//   more can sit in the skid stage, and only with both full does s_tready
//   drop.
//   Reset: pattern all zero, length 1, window empty, no word pending.
// ----------------------------------------------------------------------------
module whole_word_match_detector_top #(
    parameter int PATTERN_MAX = wwmd_pkg::PATTERN_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] text_byte
    input  logic                                s_tlast,   // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [0] word_found, [7:1] zero
    input  logic                                cfg_we,
    input  logic [wwmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wwmd_pkg::CFG_W-1:0]          cfg_data
);
    import wwmd_pkg::*;

    localparam int WIN = PATTERN_MAX + 1;

    logic [CFG_W-1:0]  pat_low_reg;
    logic [CFG_W-1:0]  pat_high_reg;
    logic [LEN_W-1:0]  pat_len_reg;
    pattern_t          pattern;
    logic [LEN_W-1:0]  len_act;

    logic              pending_reg;
    logic              pending_next;
    logic              found_reg;
    logic              found_next;

    logic              accept;
    logic              clear;
    logic              can_push;
    logic              word_found;
    logic              out_data;

    logic [BYTE_W-1:0] cell_byte  [WIN];
    logic              cell_valid [WIN];
    cell_stat_t        stat       [WIN];

    logic              all_eq;
    logic              full_seen;
    logic              left_ok;
    logic              hit;
    logic              found_acc;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PAT_LOW:  pat_low_reg  <= cfg_data;
                REG_PAT_HIGH: pat_high_reg <= cfg_data;
                REG_PAT_LEN:  pat_len_reg  <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign pattern = pattern_t'({pat_high_reg, pat_low_reg});

    always_comb
    begin
        len_act = pat_len_reg;
        if (pat_len_reg == '0)
        begin
            len_act = LEN_W'(1);
        end
        else if (pat_len_reg > LEN_W'(PATTERN_MAX))
        begin
            len_act = LEN_W'(PATTERN_MAX);
        end
    end

    // ---------------- window cells ----------------
    assign accept = s_tvalid && s_tready;
    assign clear  = s_tlast;

    for (genvar k = 0; k < WIN; k++)
    begin : g_cell
        logic [BYTE_W-1:0] in_byte;
        logic              in_valid;
        if (k == 0)
        begin : g_head
            assign in_byte  = s_tdata;
            assign in_valid = 1'b1;
        end
        else
        begin : g_link
            assign in_byte  = cell_byte[k-1];
            assign in_valid = cell_valid[k-1];
        end

        wwmd_cell #(
            .INDEX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (accept),
            .clear     (clear),
            .in_byte   (in_byte),
            .in_valid  (in_valid),
            .pattern   (pattern),
            .len       (len_act),
            .out_byte  (cell_byte[k]),
            .out_valid (cell_valid[k]),
            .stat      (stat[k])
        );
    end

    // ---------------- match decision ----------------
    always_comb
    begin
        all_eq    = 1'b1;
        full_seen = 1'b0;
        left_ok   = 1'b1;
        for (int k = 0; k < WIN; k++)
        begin
            all_eq = all_eq && stat[k].eq;
            if (LEN_W'(k + 1) == len_act)
            begin
                full_seen = stat[k].valid;
            end
            if (LEN_W'(k) == len_act)
            begin
                left_ok = !stat[k].valid || !stat[k].letter;
            end
        end
        hit       = all_eq && full_seen && left_ok;
        found_acc = found_reg || (pending_reg && !stat[0].letter);
    end

    always_comb
    begin
        pending_next = pending_reg;
        found_next   = found_reg;
        word_found   = found_acc || hit;
        if (accept)
        begin
            if (s_tlast)
            begin
                pending_next = 1'b0;
                found_next   = 1'b0;
            end
            else
            begin
                pending_next = hit;
                found_next   = found_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            found_reg   <= found_next;
        end
    end

    // ---------------- output ----------------
    wwmd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && s_tlast),
        .push_data (word_found),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign s_tready = can_push;
    assign m_tdata  = {7'b0, out_data};

    // ---------------- checks ----------------
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (!pending_reg && !found_reg && !cell_valid[0]))
        else $error("string state not cleared after last byte");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_act >= LEN_W'(1)) && (len_act <= LEN_W'(PATTERN_MAX)))
        else $error("active pattern length out of range");

    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> m_tvalid)
        else $error("no result word after last byte");

    for (genvar k = 1; k < WIN; k++)
    begin : g_chk
        a_valid_fill: assert property (@(posedge clk) disable iff (!rst_n)
            cell_valid[k] |-> cell_valid[k-1])
            else $error("window valid bits out of order");
    end

endmodule
